>>> sv/grg_pkg.sv
// shared types, constants and widths of the glyph row generator
package grg_pkg;

	localparam int HALF_ENTRIES = 256;
	localparam int FULL_ENTRIES = 8192;
	localparam int GLYPH_ROWS   = 16;

	localparam int OP_W    = 3;
	localparam int ENTRY_W = 13;
	localparam int ROW_W   = 4;
	localparam int CP_W    = 21;
	localparam int BITS_W  = 16;

	localparam int HALF_CNT_W = 9;
	localparam int FULL_CNT_W = 14;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	localparam int HALF_AW      = (HALF_ENTRIES > 1) ? $clog2(HALF_ENTRIES) : 1;
	localparam int FULL_AW      = (FULL_ENTRIES > 1) ? $clog2(FULL_ENTRIES) : 1;
	localparam int HALF_ROWS_AW = $clog2(HALF_ENTRIES * GLYPH_ROWS);
	localparam int FULL_ROWS_AW = $clog2(FULL_ENTRIES * GLYPH_ROWS);
	localparam int HALF_PIX_W   = 8;

	localparam int HALF_N_W = $clog2(HALF_ENTRIES + 1);
	localparam int FULL_N_W = $clog2(FULL_ENTRIES + 1);
	localparam int CNT_W    = (HALF_N_W > FULL_N_W) ? HALF_N_W : FULL_N_W;

	localparam logic [OP_W-1:0] OP_HALF_CODE = 3'd0;
	localparam logic [OP_W-1:0] OP_HALF_ROW  = 3'd1;
	localparam logic [OP_W-1:0] OP_FULL_CODE = 3'd2;
	localparam logic [OP_W-1:0] OP_FULL_ROW  = 3'd3;
	localparam logic [OP_W-1:0] OP_RENDER    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_COUNT = 1'd1;

	localparam logic [HALF_PIX_W-1:0] MISS_EVEN = 8'b00110011;
	localparam logic [HALF_PIX_W-1:0] MISS_ODD  = 8'b11001100;
	localparam logic [CP_W-1:0]       NARROW_MAX = 21'h7f;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [ENTRY_W-1:0] entry_index;
		logic [ROW_W-1:0]   row_index;
		logic [CP_W-1:0]    code_point;
		logic [BITS_W-1:0]  row_bits;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]  out_row;
		logic [BITS_W-1:0] pixels;
		logic              wide;
		logic              found;
		logic              last;
	} out_item_t;

endpackage

>>> sv/glyph_row_generator.sv
// glyph row generator top level: command queue front and table search back
//
// channel  direction  handshake               payload
// in       in         in_valid / in_stall     in_item (grg_pkg::in_item_t)
// out      out        out_valid / out_stall   out_item (grg_pkg::out_item_t)
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a load is queued, then written to its table when the back end takes it in idle
// a render makes ph and pf probes of ceil(log2(n+1)), one registered read of the code memories
// per probe, then one registered row read per row
// the full-width search runs only after a half-width miss
// reset clears control and counts; table contents are undefined until loaded
// out_stall holds the row register and the back end; the queue absorbs two items
module glyph_row_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  grg_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output grg_pkg::out_item_t             out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [grg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grg_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic              cmd_valid;
	logic              cmd_take;
	grg_pkg::in_item_t cmd;

	assign cfg_ready = 1'b1;

	grg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cmd_valid(cmd_valid),
		.cmd_take (cmd_take),
		.cmd      (cmd)
	);

	grg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_take (cmd_take),
		.cmd      (cmd),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

>>> sv/grg_ram.sv
// generic single write port ram with registered read
module grg_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 8,
	parameter int DEPTH  = 256
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/grg_front.sv
// input decode, filtering of dead items and two-entry command queue
module grg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  grg_pkg::in_item_t  in_item,
	output logic               cmd_valid,
	input  logic               cmd_take,
	output grg_pkg::in_item_t  cmd
);

	grg_pkg::in_item_t fifo_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              keep;
	logic              push;
	logic              pop;

	always_comb begin
		case (in_item.operation)
			grg_pkg::OP_HALF_CODE, grg_pkg::OP_HALF_ROW: begin
				keep = 32'(in_item.entry_index) < 32'(grg_pkg::HALF_ENTRIES);
			end
			grg_pkg::OP_FULL_CODE, grg_pkg::OP_FULL_ROW: begin
				keep = 32'(in_item.entry_index) < 32'(grg_pkg::FULL_ENTRIES);
			end
			grg_pkg::OP_RENDER: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall && keep;
	assign pop       = cmd_take && cmd_valid;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("command queue count out of range");

endmodule

>>> sv/grg_back.sv
// table writes, two-table binary search and row emission
module grg_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_take,
	input  grg_pkg::in_item_t                  cmd,
	input  logic                               cfg_valid,
	input  logic [grg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [grg_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output grg_pkg::out_item_t                 out_item
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_PROBE   = 3'd1;
	localparam logic [2:0] ST_CMP     = 3'd2;
	localparam logic [2:0] ST_ROW_RD  = 3'd3;
	localparam logic [2:0] ST_ROW_OUT = 3'd4;

	localparam logic [1:0] KIND_HALF = 2'd0;
	localparam logic [1:0] KIND_FULL = 2'd1;
	localparam logic [1:0] KIND_MISS = 2'd2;

	localparam int CNT_W = grg_pkg::CNT_W;
	localparam int ROW_W = grg_pkg::ROW_W;
	localparam int CP_W  = grg_pkg::CP_W;
	localparam int PW    = grg_pkg::HALF_PIX_W;

	logic [2:0]                       state_q;
	logic                             tbl_q;
	logic [1:0]                       kind_q;
	logic [CNT_W-1:0]                 lo_q;
	logic [CNT_W-1:0]                 hi_q;
	logic [CNT_W-1:0]                 mid_q;
	logic                             hit_q;
	logic [CP_W-1:0]                  key_q;
	logic [ROW_W-1:0]                 row_q;
	logic [grg_pkg::HALF_CNT_W-1:0]   half_count_q;
	logic [grg_pkg::FULL_CNT_W-1:0]   full_count_q;
	logic                             out_valid_q;
	grg_pkg::out_item_t               out_q;

	logic [CNT_W-1:0]                 half_n;
	logic [CNT_W-1:0]                 full_n;
	logic [CNT_W-1:0]                 mid;
	logic                             probe;
	logic                             out_free;
	logic                             last_row;
	logic [CP_W-1:0]                  code_rd;
	logic [PW-1:0]                    miss_byte;
	grg_pkg::out_item_t               row_item;

	logic                             hc_we, hr_we, fc_we, fr_we;
	logic                             hc_re, fc_re, hr_re, fr_re;
	logic [CP_W-1:0]                  hc_rdata, fc_rdata;
	logic [PW-1:0]                    hr_rdata;
	logic [grg_pkg::BITS_W-1:0]       fr_rdata;
	logic [grg_pkg::HALF_ROWS_AW-1:0] hr_waddr, hr_raddr;
	logic [grg_pkg::FULL_ROWS_AW-1:0] fr_waddr, fr_raddr;

	assign half_n = (32'(half_count_q) > 32'(grg_pkg::HALF_ENTRIES)) ?
		CNT_W'(grg_pkg::HALF_ENTRIES) : CNT_W'(half_count_q);
	assign full_n = (32'(full_count_q) > 32'(grg_pkg::FULL_ENTRIES)) ?
		CNT_W'(grg_pkg::FULL_ENTRIES) : CNT_W'(full_count_q);

	assign cmd_take = (state_q == ST_IDLE) && cmd_valid;
	assign hc_we    = cmd_take && (cmd.operation == grg_pkg::OP_HALF_CODE);
	assign hr_we    = cmd_take && (cmd.operation == grg_pkg::OP_HALF_ROW);
	assign fc_we    = cmd_take && (cmd.operation == grg_pkg::OP_FULL_CODE);
	assign fr_we    = cmd_take && (cmd.operation == grg_pkg::OP_FULL_ROW);

	assign hr_waddr = grg_pkg::HALF_ROWS_AW'({grg_pkg::HALF_AW'(cmd.entry_index),
		cmd.row_index});
	assign fr_waddr = grg_pkg::FULL_ROWS_AW'({grg_pkg::FULL_AW'(cmd.entry_index),
		cmd.row_index});
	assign hr_raddr = grg_pkg::HALF_ROWS_AW'({grg_pkg::HALF_AW'(lo_q), row_q});
	assign fr_raddr = grg_pkg::FULL_ROWS_AW'({grg_pkg::FULL_AW'(lo_q), row_q});

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign probe   = (state_q == ST_PROBE) && (lo_q < hi_q);
	assign hc_re   = probe && !tbl_q;
	assign fc_re   = probe && tbl_q;
	assign hr_re   = (state_q == ST_ROW_RD) && (kind_q == KIND_HALF);
	assign fr_re   = (state_q == ST_ROW_RD) && (kind_q == KIND_FULL);
	assign code_rd = tbl_q ? fc_rdata : hc_rdata;

	assign out_free = !out_valid_q || !out_stall;
	assign last_row = (row_q == ROW_W'(grg_pkg::GLYPH_ROWS - 1));

	assign miss_byte = row_q[0] ? grg_pkg::MISS_ODD : grg_pkg::MISS_EVEN;

	always_comb begin
		row_item.out_row = row_q;
		row_item.last    = last_row;
		case (kind_q)
			KIND_HALF: begin
				row_item.pixels = {hr_rdata, {PW{1'b0}}};
				row_item.wide   = 1'b0;
				row_item.found  = 1'b1;
			end
			KIND_FULL: begin
				row_item.pixels = fr_rdata;
				row_item.wide   = 1'b1;
				row_item.found  = 1'b1;
			end
			default: begin
				row_item.wide   = (key_q > grg_pkg::NARROW_MAX);
				row_item.pixels = row_item.wide ? {miss_byte, miss_byte} :
					{miss_byte, {PW{1'b0}}};
				row_item.found  = 1'b0;
			end
		endcase
	end

	grg_ram #(
		.DATA_W(CP_W),
		.ADDR_W(grg_pkg::HALF_AW),
		.DEPTH (grg_pkg::HALF_ENTRIES)
	) u_half_codes (
		.clk  (clk),
		.we   (hc_we),
		.waddr(grg_pkg::HALF_AW'(cmd.entry_index)),
		.wdata(cmd.code_point),
		.re   (hc_re),
		.raddr(grg_pkg::HALF_AW'(mid)),
		.rdata(hc_rdata)
	);

	grg_ram #(
		.DATA_W(PW),
		.ADDR_W(grg_pkg::HALF_ROWS_AW),
		.DEPTH (grg_pkg::HALF_ENTRIES * grg_pkg::GLYPH_ROWS)
	) u_half_rows (
		.clk  (clk),
		.we   (hr_we),
		.waddr(hr_waddr),
		.wdata(cmd.row_bits[PW-1:0]),
		.re   (hr_re),
		.raddr(hr_raddr),
		.rdata(hr_rdata)
	);

	grg_ram #(
		.DATA_W(CP_W),
		.ADDR_W(grg_pkg::FULL_AW),
		.DEPTH (grg_pkg::FULL_ENTRIES)
	) u_full_codes (
		.clk  (clk),
		.we   (fc_we),
		.waddr(grg_pkg::FULL_AW'(cmd.entry_index)),
		.wdata(cmd.code_point),
		.re   (fc_re),
		.raddr(grg_pkg::FULL_AW'(mid)),
		.rdata(fc_rdata)
	);

	grg_ram #(
		.DATA_W(grg_pkg::BITS_W),
		.ADDR_W(grg_pkg::FULL_ROWS_AW),
		.DEPTH (grg_pkg::FULL_ENTRIES * grg_pkg::GLYPH_ROWS)
	) u_full_rows (
		.clk  (clk),
		.we   (fr_we),
		.waddr(fr_waddr),
		.wdata(cmd.row_bits),
		.re   (fr_re),
		.raddr(fr_raddr),
		.rdata(fr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_count_q <= '0;
			full_count_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				grg_pkg::REG_HALF_COUNT: begin
					half_count_q <= cfg_data[grg_pkg::HALF_CNT_W-1:0];
				end
				grg_pkg::REG_FULL_COUNT: begin
					full_count_q <= cfg_data[grg_pkg::FULL_CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROW_OUT && out_free) begin
			out_q <= row_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tbl_q       <= 1'b0;
			kind_q      <= KIND_MISS;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			hit_q       <= 1'b0;
			key_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_take && cmd.operation == grg_pkg::OP_RENDER) begin
						key_q   <= cmd.code_point;
						tbl_q   <= 1'b0;
						lo_q    <= '0;
						hi_q    <= half_n;
						hit_q   <= 1'b0;
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (probe) begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end else if (hit_q) begin
						kind_q  <= tbl_q ? KIND_FULL : KIND_HALF;
						row_q   <= '0;
						state_q <= ST_ROW_RD;
					end else if (!tbl_q) begin
						tbl_q <= 1'b1;
						lo_q  <= '0;
						hi_q  <= full_n;
					end else begin
						kind_q  <= KIND_MISS;
						row_q   <= '0;
						state_q <= ST_ROW_RD;
					end
				end
				ST_CMP: begin
					if (code_rd < key_q) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q  <= mid_q;
						hit_q <= (code_rd == key_q);
					end
					state_q <= ST_PROBE;
				end
				ST_ROW_RD: begin
					state_q <= ST_ROW_OUT;
				end
				ST_ROW_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						row_q       <= row_q + 1'b1;
						state_q     <= last_row ? ST_IDLE : ST_ROW_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_cmp_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> $past(state_q) == ST_PROBE)
		else $error("compare without a probe read");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE || state_q == ST_CMP) |-> lo_q <= hi_q)
		else $error("search bounds crossed");

	a_cmp_mid_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> (mid_q >= lo_q && mid_q < hi_q))
		else $error("probe outside search window");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.last == (out_q.out_row == ROW_W'(grg_pkg::GLYPH_ROWS - 1)))
		else $error("last flag not on final row");

endmodule
